FILE: rtl/dvse_pkg.sv
package dvse_pkg;

    // DEX value type codes
    localparam logic [4:0] TY_BYTE   = 5'd0;
    localparam logic [4:0] TY_SHORT  = 5'd2;
    localparam logic [4:0] TY_CHAR   = 5'd3;
    localparam logic [4:0] TY_INT    = 5'd4;
    localparam logic [4:0] TY_LONG   = 5'd6;
    localparam logic [4:0] TY_FLOAT  = 5'd16;
    localparam logic [4:0] TY_DOUBLE = 5'd17;
    localparam logic [4:0] TY_STRING = 5'd23;
    localparam logic [4:0] TY_TYPE   = 5'd24;
    localparam logic [4:0] TY_FIELD  = 5'd25;
    localparam logic [4:0] TY_METHOD = 5'd26;
    localparam logic [4:0] TY_ENUM   = 5'd27;
    localparam logic [4:0] TY_NULL   = 5'd30;
    localparam logic [4:0] TY_BOOL   = 5'd31;

    localparam logic [31:0] IDX_NOT_FOUND = 32'hFFFF_FFFF;

    // Payload byte counts
    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_MAX  = 4'd8;

    // Decoded request: type, payload, byte count (or max count when sized)
    typedef struct packed {
        logic [4:0]  typ;
        logic [63:0] pay;
        logic        sized;
        logic [3:0]  len;
        logic [2:0]  hdr_hi;
    } dec_t;

    // Ready-to-send frame: header byte, payload, payload byte count
    typedef struct packed {
        logic [7:0]  hdr;
        logic [63:0] pay;
        logic [3:0]  len;
    } frm_t;

endpackage

FILE: rtl/dvse_decode.sv
module dvse_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         opcode,
    input  logic [63:0]        value_bits,
    input  logic [31:0]        pool_index,
    output logic               out_valid,
    input  logic               out_ready,
    output dvse_pkg::dec_t     out_dec
);

    logic            vld_reg;
    logic            vld_next;
    dvse_pkg::dec_t  dec_reg;
    dvse_pkg::dec_t  dec_next;
    logic [31:0]     idx_z;
    logic            load;

    assign in_ready  = !vld_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign out_dec   = dec_reg;

    assign idx_z = (pool_index == dvse_pkg::IDX_NOT_FOUND) ? 32'd0 : pool_index;

    always_comb begin
        dec_next.typ    = opcode;
        dec_next.pay    = 64'd0;
        dec_next.sized  = 1'b0;
        dec_next.len    = 4'd1;
        dec_next.hdr_hi = 3'd0;
        unique case (opcode)
            dvse_pkg::TY_BYTE: begin
                dec_next.pay = {56'd0, value_bits[7:0]};
            end
            dvse_pkg::TY_SHORT, dvse_pkg::TY_CHAR: begin
                dec_next.pay = {48'd0, value_bits[15:0]};
                dec_next.len = 4'd2;
            end
            dvse_pkg::TY_INT: begin
                dec_next.pay   = {{32{value_bits[31]}}, value_bits[31:0]};
                dec_next.sized = 1'b1;
                dec_next.len   = 4'd4;
            end
            dvse_pkg::TY_LONG: begin
                dec_next.pay   = value_bits;
                dec_next.sized = 1'b1;
                dec_next.len   = dvse_pkg::LEN_MAX;
            end
            dvse_pkg::TY_FLOAT: begin
                dec_next.pay = {32'd0, value_bits[31:0]};
                dec_next.len = 4'd4;
            end
            dvse_pkg::TY_DOUBLE: begin
                dec_next.pay = value_bits;
                dec_next.len = dvse_pkg::LEN_MAX;
            end
            dvse_pkg::TY_STRING, dvse_pkg::TY_TYPE, dvse_pkg::TY_FIELD,
            dvse_pkg::TY_METHOD, dvse_pkg::TY_ENUM: begin
                dec_next.pay = {40'd0, idx_z[23:0]};
                dec_next.len = (idx_z[31:16] != 16'd0) ? 4'd3 : 4'd2;
            end
            dvse_pkg::TY_NULL: begin
                dec_next.len = dvse_pkg::LEN_NONE;
            end
            dvse_pkg::TY_BOOL: begin
                dec_next.len    = dvse_pkg::LEN_NONE;
                dec_next.hdr_hi = {2'b00, |value_bits};
            end
            default: begin
                // unknown, array, annotation: int zero
                dec_next.typ = dvse_pkg::TY_INT;
            end
        endcase
    end

    always_comb begin
        vld_next = vld_reg;
        if (in_ready) begin
            vld_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            dec_reg <= dec_next;
        end
    end

endmodule

FILE: rtl/dvse_size.sv
module dvse_size (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  dvse_pkg::dec_t     in_dec,
    output logic               out_valid,
    input  logic               out_ready,
    output dvse_pkg::frm_t     out_frm
);

    logic            vld_reg;
    logic            vld_next;
    dvse_pkg::frm_t  frm_reg;
    dvse_pkg::frm_t  frm_next;
    logic [7:1]      fits;
    logic [3:0]      n_min;
    logic [3:0]      len_sel;
    logic            load;

    assign in_ready  = !vld_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign out_frm   = frm_reg;

    // fits[n]: value holds in n signed bytes (bits above 8n-1 all sign)
    for (genvar n = 1; n < 8; n++) begin : g_fit
        localparam int SH = 8 * n - 1;
        logic [63-SH:0] top;
        assign top     = in_dec.pay[63:SH];
        assign fits[n] = (top == '0) || (top == '1);
    end

    always_comb begin
        n_min = in_dec.len;
        for (int n = 7; n >= 1; n--) begin
            if ((4'(n) < in_dec.len) && fits[n]) begin
                n_min = 4'(n);
            end
        end
    end

    always_comb begin
        len_sel      = in_dec.sized ? n_min : in_dec.len;
        frm_next.len = len_sel;
        frm_next.pay = in_dec.pay;
        if (len_sel == dvse_pkg::LEN_NONE) begin
            frm_next.hdr = {in_dec.hdr_hi, in_dec.typ};
        end else begin
            frm_next.hdr = {3'(len_sel - 4'd1), in_dec.typ};
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (in_ready) begin
            vld_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frm_reg <= frm_next;
        end
    end

endmodule

FILE: rtl/dvse_serial.sv
module dvse_serial (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  dvse_pkg::frm_t     in_frm,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last_byte
);

    logic         busy_reg;
    logic         busy_next;
    logic [7:0]   byte_reg;
    logic [7:0]   byte_next;
    logic [63:0]  pay_reg;
    logic [63:0]  pay_next;
    logic [3:0]   cnt_reg;
    logic [3:0]   cnt_next;
    logic         fin;
    logic         load;

    // cnt_reg: payload bytes still to send after the one on the port
    assign fin         = (cnt_reg == dvse_pkg::LEN_NONE);
    assign in_ready    = !busy_reg || (m_ready && fin);
    assign load        = in_valid && in_ready;
    assign m_valid     = busy_reg;
    assign m_out_byte  = byte_reg;
    assign m_last_byte = fin;

    always_comb begin
        busy_next = busy_reg;
        byte_next = byte_reg;
        pay_next  = pay_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            // header first, payload waits in pay_reg
            busy_next = 1'b1;
            byte_next = in_frm.hdr;
            pay_next  = in_frm.pay;
            cnt_next  = in_frm.len;
        end else if (busy_reg && m_ready) begin
            if (fin) begin
                busy_next = 1'b0;
            end else begin
                byte_next = pay_reg[7:0];
                pay_next  = {8'd0, pay_reg[63:8]};
                cnt_next  = cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= dvse_pkg::LEN_NONE;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        pay_reg  <= pay_next;
    end

endmodule

FILE: rtl/dex_encoded_value_scalar_encoder_top.sv
// Channel   Ports                                    Direction  Moves
// s_        s_valid/s_ready, opcode, value, index    in         one scalar request
// m_        m_valid/m_ready, out_byte, last_byte     out        one encoded byte
//
// Pipeline: decode -> size -> serializer; the header byte reaches m_ through the
// decode, size and serializer registers. Each request produces 1 to 9 bytes, one
// per cycle while m_ready is high; the serializer takes no new frame before the
// current frame's last byte, and loads the next frame on the edge that takes it.
// Reset (aresetn low at a clock edge) empties every stage; payload regs keep junk.
// A stall on m_ready backs up stage by stage; nothing is dropped or repeated.
module dex_encoded_value_scalar_encoder_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [4:0]   s_opcode,
    input  logic [63:0]  s_value_bits,
    input  logic [31:0]  s_pool_index,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_out_byte,
    output logic         m_last_byte
);

    // decode -> size
    logic            dec_valid;
    logic            dec_ready;
    dvse_pkg::dec_t  dec;

    // size -> serializer
    logic            frm_valid;
    logic            frm_ready;
    dvse_pkg::frm_t  frm;

    // Stage 1: type decode, payload select, index not-found fixup
    dvse_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .opcode     (s_opcode),
        .value_bits (s_value_bits),
        .pool_index (s_pool_index),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .out_dec    (dec)
    );

    // Stage 2: minimum signed width for int/long, header byte build
    dvse_size u_size (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_dec    (dec),
        .out_valid (frm_valid),
        .out_ready (frm_ready),
        .out_frm   (frm)
    );

    // Stage 3: header then payload bytes, LSB first; loads next frame on last byte
    dvse_serial u_serial (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (frm_valid),
        .in_ready    (frm_ready),
        .in_frm      (frm),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

FILE: rtl/dvse_chk.sv
module dvse_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_ready,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_last_byte
);

    // reset empties the output
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // stalled byte holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_byte))
        else $error("output changed under stall");

    // a request's bytes come without gaps
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_byte |=> m_valid)
        else $error("gap inside a request's bytes");

    // input only backs up when the output holds a byte
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

endmodule

bind dex_encoded_value_scalar_encoder_top dvse_chk u_chk (.*);
